@@ src/fmpf_pkg.sv @@
// Package: constants and the rule record type for the first-match packet filter.
`timescale 1ns / 1ps
package fmpf_pkg;
	localparam int NUM_LISTS_DEF      = 2;
	localparam int RULES_PER_LIST_DEF = 16;

	localparam logic [1:0] MODE_CHECK = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_CLRH  = 2'd3;

	localparam logic [15:0] ETY_ARP  = 16'h0806;
	localparam logic [15:0] ETY_IPV4 = 16'h0800;
	localparam logic [7:0]  PR_ICMP  = 8'd1;
	localparam logic [7:0]  PR_TCP   = 8'd6;
	localparam logic [7:0]  PR_UDP   = 8'd17;
	localparam logic [15:0] LEN_ETH  = 16'd14;
	localparam logic [15:0] LEN_IP   = 16'd34;
	localparam logic [15:0] LEN_UDP  = 16'd42;
	localparam logic [15:0] LEN_TCP  = 16'd54;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] src_mask;
		logic [31:0] dst;
		logic [31:0] dst_mask;
		logic [7:0]  proto;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  act;
	} rule_t;
endpackage

@@ src/first_match_packet_filter.sv @@
// First-match packet filter: rule memory, hit counters and a rule-by-rule scan sequencer.
// Check: goes straight to the result when the header or list number decides; otherwise each
// rule of the list is read and then compared in turn until a hit or the end of the list.
// Add rule: written straight from idle. Clear list or hit counts: one counter a cycle.
// Busy is low during the one-cycle result strobe, so the next item is taken at the edge that
// ends it. Reset clears list fill counts and totals; rule and hit memories hold no reset value.
`timescale 1ns / 1ps
module first_match_packet_filter #(
	parameter int NUM_LISTS      = fmpf_pkg::NUM_LISTS_DEF,
	parameter int RULES_PER_LIST = fmpf_pkg::RULES_PER_LIST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  mode,
	input  logic [7:0]  list_sel,
	input  logic [15:0] ether_type,
	input  logic [15:0] frame_length,
	input  logic [7:0]  ip_proto,
	input  logic [31:0] src_addr,
	input  logic [31:0] src_mask,
	input  logic [31:0] dst_addr,
	input  logic [31:0] dst_mask,
	input  logic [15:0] source_port,
	input  logic [15:0] dst_port,
	input  logic [7:0]  rule_action,
	output logic [7:0]  verdict,
	output logic        rule_matched,
	output logic [3:0]  matched_rule,
	output logic [31:0] rule_hits,
	output logic        op_ok,
	output logic        list_empty,
	output logic [31:0] allow_total,
	output logic [31:0] deny_total
);
	import fmpf_pkg::*;

	localparam int TOTAL = NUM_LISTS * RULES_PER_LIST;
	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int FW = $clog2(RULES_PER_LIST + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_HIT  = 3'd3;
	localparam logic [2:0] ST_CLR  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	rule_t       rule_mem [TOTAL];
	logic [31:0] hit_mem  [TOTAL];

	logic [2:0]    state_q;
	logic [FW-1:0] fill_q [NUM_LISTS];
	logic [31:0]   allow_q, deny_q;

	logic [LW-1:0] list_q;
	logic        valid_q;
	logic [7:0]  proto_q;
	logic [31:0] sa_q, da_q;
	logic [15:0] sp_q, dp_q;
	logic [FW-1:0] idx_q;
	logic [AW-1:0] addr_q;
	rule_t       rd_rule_q;
	logic [31:0] rd_hit_q;

	logic [7:0]  verdict_q;
	logic        matched_q, ok_q, done_q;
	logic [3:0]  midx_q;
	logic [31:0] hits_q;

	logic        sel_valid;
	logic [LW-1:0] sel_list;
	logic        pre_scan, pre_allow, pre_count;
	logic        rule_hit;
	logic [FW-1:0] cur_fill;
	logic [AW-1:0] base_addr;

	assign sel_valid = {24'd0, list_sel} < 32'(NUM_LISTS);
	assign sel_list  = list_sel[LW-1:0];
	assign cur_fill  = fill_q[list_q];
	assign base_addr = AW'(32'(list_q) * 32'(RULES_PER_LIST));

	// Header pre-checks decide before any rule is read.
	always_comb begin
		pre_scan  = 1'b0;
		pre_allow = 1'b0;
		pre_count = 1'b1;
		if (frame_length < LEN_ETH) begin
			pre_count = 1'b0;
		end else if (ether_type == ETY_ARP) begin
			pre_allow = 1'b1;
		end else if (ether_type != ETY_IPV4 || frame_length < LEN_IP) begin
			pre_scan = 1'b0;
		end else if (ip_proto == PR_UDP) begin
			pre_scan = frame_length >= LEN_UDP;
		end else if (ip_proto == PR_TCP) begin
			pre_scan = frame_length >= LEN_TCP;
		end else if (ip_proto == PR_ICMP) begin
			pre_scan = 1'b1;
		end
	end

	always_comb begin
		rule_hit = (rd_rule_q.proto == 8'd0 || rd_rule_q.proto == proto_q) &&
			(rd_rule_q.src == 32'd0 || rd_rule_q.src == (sa_q & rd_rule_q.src_mask)) &&
			(rd_rule_q.dst == 32'd0 || rd_rule_q.dst == (da_q & rd_rule_q.dst_mask)) &&
			(rd_rule_q.sport == 16'd0 || rd_rule_q.sport == sp_q) &&
			(rd_rule_q.dport == 16'd0 || rd_rule_q.dport == dp_q);
	end

	// Memories: one write port each, registered reads.
	always_ff @(posedge clk) begin
		rd_rule_q <= rule_mem[addr_q];
		rd_hit_q  <= hit_mem[addr_q];
		if (state_q == ST_IDLE && start && mode == MODE_ADD && sel_valid &&
			fill_q[sel_list] < FW'(RULES_PER_LIST)) begin
			rule_mem[AW'(32'(sel_list) * 32'(RULES_PER_LIST) + 32'(fill_q[sel_list]))] <=
				'{src: src_addr & src_mask, src_mask: src_mask,
				  dst: dst_addr & dst_mask, dst_mask: dst_mask, proto: ip_proto,
				  sport: source_port, dport: dst_port, act: rule_action};
			hit_mem[AW'(32'(sel_list) * 32'(RULES_PER_LIST) + 32'(fill_q[sel_list]))] <=
				32'd0;
		end else if (state_q == ST_HIT) begin
			hit_mem[addr_q] <= rd_hit_q + 32'd1;
		end else if (state_q == ST_CLR) begin
			hit_mem[addr_q] <= 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_LISTS; i++) fill_q[i] <= '0;
			allow_q <= '0;
			deny_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						list_q    <= sel_list;
						valid_q   <= sel_valid;
						proto_q   <= ip_proto;
						sa_q      <= src_addr;
						da_q      <= dst_addr;
						sp_q      <= (ip_proto == PR_ICMP) ? 16'd0 : source_port;
						dp_q      <= (ip_proto == PR_ICMP) ? 16'd0 : dst_port;
						idx_q     <= '0;
						addr_q    <= AW'(32'(sel_list) * 32'(RULES_PER_LIST));
						verdict_q <= '0;
						matched_q <= 1'b0;
						midx_q    <= '0;
						hits_q    <= '0;
						ok_q      <= sel_valid;
						state_q   <= ST_DONE;
						case (mode)
							MODE_CHECK: begin
								if (sel_valid) begin
									if (pre_scan) begin
										state_q <= ST_RD;
									end else if (pre_count) begin
										if (pre_allow) begin
											verdict_q <= 8'd1;
											allow_q   <= allow_q + 32'd1;
										end else begin
											deny_q <= deny_q + 32'd1;
										end
									end
								end
							end
							MODE_ADD: begin
								if (sel_valid && fill_q[sel_list] < FW'(RULES_PER_LIST)) begin
									fill_q[sel_list] <= fill_q[sel_list] + FW'(1);
								end else begin
									ok_q <= 1'b0;
								end
							end
							MODE_CLEAR: begin
								if (sel_valid) begin
									fill_q[sel_list] <= '0;
									state_q <= ST_CLR;
								end
							end
							default: begin
								if (sel_valid) state_q <= ST_CLR;
							end
						endcase
					end
				end
				ST_RD: begin
					// Wait for the registered read of the next rule.
					if (idx_q >= cur_fill) begin
						deny_q  <= deny_q + 32'd1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (rule_hit) begin
						verdict_q <= rd_rule_q.act;
						matched_q <= 1'b1;
						midx_q    <= 4'(idx_q);
						hits_q    <= rd_hit_q + 32'd1;
						if (rd_rule_q.act[0]) allow_q <= allow_q + 32'd1;
						else deny_q <= deny_q + 32'd1;
						state_q <= ST_HIT;
					end else begin
						idx_q   <= idx_q + FW'(1);
						addr_q  <= addr_q + AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_HIT: begin
					state_q <= ST_DONE;
				end
				ST_CLR: begin
					// Zero one hit counter per cycle across the list.
					if (idx_q == FW'(RULES_PER_LIST - 1)) begin
						state_q <= ST_DONE;
					end else begin
						idx_q  <= idx_q + FW'(1);
						addr_q <= base_addr + AW'(idx_q + FW'(1));
					end
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign verdict      = verdict_q;
	assign rule_matched = matched_q;
	assign matched_rule = midx_q;
	assign rule_hits    = hits_q;
	assign op_ok        = ok_q;
	assign list_empty   = !valid_q || (cur_fill == '0);
	assign allow_total  = allow_q;
	assign deny_total   = deny_q;
endmodule
